[src/tvs_pkg.sv]
// shared types and constants of the trilinear volume sampler
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

    // fixed field widths
    localparam int COORD_W     = 18;
    localparam int ADDR_IN_W   = 18;
    localparam int VALUE_IN_W  = 16;
    localparam int DIM_W       = 7;
    localparam int DIM_XY_W    = 2 * DIM_W;
    localparam int CELL_ADDR_W = 3 * DIM_W;
    localparam int OUT_W       = 40;
    localparam int IDX_W       = DIM_W;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [DIM_W-1:0]    DIM_RESET    = 7'd64;
    localparam logic [DIM_XY_W-1:0] DIM_XY_RESET = 14'd4096;
    localparam logic [2:0]          LAST_CORNER  = 3'd7;

    // register indexes on the config port
    localparam logic [1:0] REG_DIM_X = 2'd0;
    localparam logic [1:0] REG_DIM_Y = 2'd1;
    localparam logic [1:0] REG_DIM_Z = 2'd2;

    // control bits of one queued command
    typedef struct packed {
        logic is_sample;
        logic in_cell;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

[src/tvs_front.sv]
// front end: takes beats, splits coordinates, checks the cell and forms the base address
`timescale 1ns / 1ps
`default_nettype none

module tvs_front #(
    parameter int VOXEL_BITS    = 16,
    parameter int FRACTION_BITS = 8,
    parameter int CA_W          = 21
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    output logic                                    o_busy,
    input  wire                                     i_action,
    input  wire        [tvs_pkg::ADDR_IN_W-1:0]     i_voxel_address,
    input  wire signed [tvs_pkg::VALUE_IN_W-1:0]    i_voxel_value,
    input  wire signed [tvs_pkg::COORD_W-1:0]       i_coord_x,
    input  wire signed [tvs_pkg::COORD_W-1:0]       i_coord_y,
    input  wire signed [tvs_pkg::COORD_W-1:0]       i_coord_z,
    input  wire        [tvs_pkg::DIM_W-1:0]         i_dim_x,
    input  wire        [tvs_pkg::DIM_W-1:0]         i_dim_y,
    input  wire        [tvs_pkg::DIM_W-1:0]         i_dim_z,
    input  wire        [tvs_pkg::DIM_XY_W-1:0]      i_dim_xy,
    input  wire        [tvs_pkg::Q_CNT_W-1:0]       i_q_count,
    output logic                                    o_push,
    output tvs_pkg::t_cmd_ctl                       o_push_ctl,
    output logic       [CA_W-1:0]                   o_push_addr,
    output logic       [VOXEL_BITS-1:0]             o_push_value,
    output logic       [FRACTION_BITS-1:0]          o_push_fx,
    output logic       [FRACTION_BITS-1:0]          o_push_fy,
    output logic       [FRACTION_BITS-1:0]          o_push_fz
);

    localparam int CW    = tvs_pkg::COORD_W;
    localparam int INT_W = CW - FRACTION_BITS;
    localparam int CMP_W = (INT_W + 1 > 8) ? INT_W + 1 : 8;
    localparam int XW    = tvs_pkg::IDX_W;

    logic                   w_accept;
    logic [tvs_pkg::Q_CNT_W:0] w_in_flight;

    // stage 1: captured beat
    logic                   r1_v;
    logic                   r1_sample;
    logic [tvs_pkg::ADDR_IN_W-1:0] r1_waddr;
    logic [VOXEL_BITS-1:0]  r1_value;
    logic [CW-1:0]          r1_cx;
    logic [CW-1:0]          r1_cy;
    logic [CW-1:0]          r1_cz;

    logic [INT_W-1:0]       w_int_x;
    logic [INT_W-1:0]       w_int_y;
    logic [INT_W-1:0]       w_int_z;
    logic [CMP_W-1:0]       w_ext_x;
    logic [CMP_W-1:0]       w_ext_y;
    logic [CMP_W-1:0]       w_ext_z;
    logic                   w_in_cell;

    // stage 2: index products
    logic                   r2_v;
    logic                   r2_sample;
    logic                   r2_in_cell;
    logic [tvs_pkg::ADDR_IN_W-1:0] r2_waddr;
    logic [VOXEL_BITS-1:0]  r2_value;
    logic [XW-1:0]          r2_x;
    logic [tvs_pkg::DIM_XY_W-1:0]    r2_py;
    logic [tvs_pkg::CELL_ADDR_W-1:0] r2_pz;
    logic [FRACTION_BITS-1:0] r2_fx;
    logic [FRACTION_BITS-1:0] r2_fy;
    logic [FRACTION_BITS-1:0] r2_fz;

    // credit check: the queue always has room for everything in flight
    assign w_in_flight = {1'b0, i_q_count} + (tvs_pkg::Q_CNT_W + 1)'(r1_v)
                       + (tvs_pkg::Q_CNT_W + 1)'(r2_v);
    assign o_busy   = (w_in_flight >= (tvs_pkg::Q_CNT_W + 1)'(tvs_pkg::Q_DEPTH));
    assign w_accept = i_start && !o_busy;

    // floor is the upper bits, fraction the lower bits
    assign w_int_x = r1_cx[CW-1:FRACTION_BITS];
    assign w_int_y = r1_cy[CW-1:FRACTION_BITS];
    assign w_int_z = r1_cz[CW-1:FRACTION_BITS];
    assign w_ext_x = CMP_W'(w_int_x);
    assign w_ext_y = CMP_W'(w_int_y);
    assign w_ext_z = CMP_W'(w_int_z);

    assign w_in_cell = !r1_cx[CW-1] && !r1_cy[CW-1] && !r1_cz[CW-1]
                    && ((w_ext_x + CMP_W'(1)) < CMP_W'(i_dim_x))
                    && ((w_ext_y + CMP_W'(1)) < CMP_W'(i_dim_y))
                    && ((w_ext_z + CMP_W'(1)) < CMP_W'(i_dim_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= w_accept;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_sample <= i_action;
            r1_waddr  <= i_voxel_address;
            r1_value  <= VOXEL_BITS'(i_voxel_value);
            r1_cx     <= i_coord_x;
            r1_cy     <= i_coord_y;
            r1_cz     <= i_coord_z;
        end
        r2_sample  <= r1_sample;
        r2_in_cell <= w_in_cell;
        r2_waddr   <= r1_waddr;
        r2_value   <= r1_value;
        r2_x       <= w_ext_x[XW-1:0];
        r2_py      <= w_ext_y[XW-1:0] * i_dim_x;
        r2_pz      <= w_ext_z[XW-1:0] * i_dim_xy;
        r2_fx      <= r1_cx[FRACTION_BITS-1:0];
        r2_fy      <= r1_cy[FRACTION_BITS-1:0];
        r2_fz      <= r1_cz[FRACTION_BITS-1:0];
    end

    assign o_push               = r2_v;
    assign o_push_ctl.is_sample = r2_sample;
    assign o_push_ctl.in_cell   = r2_in_cell;
    assign o_push_addr  = r2_sample ? (CA_W'(r2_x) + CA_W'(r2_py) + CA_W'(r2_pz))
                                    : CA_W'(r2_waddr);
    assign o_push_value = r2_value;
    assign o_push_fx    = r2_fx;
    assign o_push_fy    = r2_fy;
    assign o_push_fz    = r2_fz;

`ifndef SYNTH
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < tvs_pkg::Q_CNT_W'(tvs_pkg::Q_DEPTH)))
        else $error("front pushed into a full queue");
`endif

endmodule

`default_nettype wire

[src/tvs_queue.sv]
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module tvs_queue #(
    parameter int DATA_W = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_push,
    input  wire  [DATA_W-1:0]              i_data,
    input  wire                            i_pop,
    output logic [DATA_W-1:0]              o_data,
    output logic                           o_valid,
    output logic [tvs_pkg::Q_CNT_W-1:0]    o_count
);

    logic [DATA_W-1:0]               r_slot [tvs_pkg::Q_DEPTH];
    logic [tvs_pkg::Q_PTR_W-1:0]     r_wp;
    logic [tvs_pkg::Q_PTR_W-1:0]     r_rp;
    logic [tvs_pkg::Q_CNT_W-1:0]     r_count;
    logic                            w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + tvs_pkg::Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + tvs_pkg::Q_PTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + tvs_pkg::Q_CNT_W'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - tvs_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rp];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

[src/tvs_back.sv]
// back end: voxel memory, eight-corner read sequence, weight products and accumulation
`timescale 1ns / 1ps
`default_nettype none

module tvs_back #(
    parameter int VOXEL_CAPACITY = 262144,
    parameter int VOXEL_BITS     = 16,
    parameter int FRACTION_BITS  = 8,
    parameter int MEM_AW         = 18,
    parameter int CA_W           = 21
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_q_valid,
    input  tvs_pkg::t_cmd_ctl                     i_q_ctl,
    input  wire         [CA_W-1:0]                i_q_addr,
    input  wire         [VOXEL_BITS-1:0]          i_q_value,
    input  wire         [FRACTION_BITS-1:0]       i_q_fx,
    input  wire         [FRACTION_BITS-1:0]       i_q_fy,
    input  wire         [FRACTION_BITS-1:0]       i_q_fz,
    input  wire         [tvs_pkg::DIM_W-1:0]      i_dim_x,
    input  wire         [tvs_pkg::DIM_XY_W-1:0]   i_dim_xy,
    output logic                                  o_q_pop,
    output logic                                  o_result_valid,
    output logic signed [tvs_pkg::OUT_W-1:0]      o_sample_value,
    output logic                                  o_inside_res
);

    localparam int FB    = FRACTION_BITS;
    localparam int AW1   = CA_W + 1;
    localparam int OW    = tvs_pkg::OUT_W;
    localparam int P1_W  = VOXEL_BITS + FB + 2;
    localparam int P2_W  = P1_W + FB + 2;
    localparam int P3F_W = P2_W + FB + 2;
    localparam int EXT_W = (P3F_W > OW) ? P3F_W : OW;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    tvs_pkg::t_back_state r_state;
    tvs_pkg::t_back_state n_state;

    logic                   w_pop;
    logic                   w_mem_we;
    logic                   w_issue;
    logic                   w_finish;
    logic                   w_pipe_empty;
    logic                   w_start_cell;
    logic                   w_outside;

    logic [AW1-1:0]         w_cap;
    logic [AW1-1:0]         w_caddr;
    logic                   w_corner_oob;
    logic                   w_wr_ok;

    logic [CA_W-1:0]        r_base;
    logic [FB-1:0]          r_fx;
    logic [FB-1:0]          r_fy;
    logic [FB-1:0]          r_fz;
    logic [2:0]             r_corner;

    logic [VOXEL_BITS-1:0]  r_voxel_mem [VOXEL_CAPACITY];
    logic [VOXEL_BITS-1:0]  r_rdata;

    // product pipeline
    logic                   r_t1_v;
    logic                   r_t1_zero;
    logic [2:0]             r_t1_corner;
    logic                   r_t2_v;
    logic [1:0]             r_t2_corner;
    logic                   r_t3_v;
    logic                   r_t3_corner;
    logic                   r_t4_v;
    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic signed [OW-1:0]   r_p3;
    logic signed [OW-1:0]   r_acc;

    logic signed [VOXEL_BITS-1:0] w_vox;
    logic [FB:0]            w_wx;
    logic [FB:0]            w_wy;
    logic [FB:0]            w_wz;
    logic signed [EXT_W-1:0] w_p3;

    logic                   r_out_valid;
    logic                   r_out_inside;
    logic signed [OW-1:0]   r_out_value;

    assign w_cap        = AW1'(VOXEL_CAPACITY);
    assign w_caddr      = AW1'(r_base) + AW1'(r_corner[0])
                        + (r_corner[1] ? AW1'(i_dim_x)  : '0)
                        + (r_corner[2] ? AW1'(i_dim_xy) : '0);
    assign w_corner_oob = (w_caddr >= w_cap);
    assign w_wr_ok      = (AW1'(i_q_addr) < w_cap);
    assign w_pipe_empty = !(r_t1_v || r_t2_v || r_t3_v || r_t4_v);
    assign w_start_cell = i_q_valid && i_q_ctl.is_sample && i_q_ctl.in_cell;
    assign w_outside    = i_q_valid && i_q_ctl.is_sample && !i_q_ctl.in_cell;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tvs_pkg::B_IDLE: begin
                if (w_start_cell) begin
                    n_state = tvs_pkg::B_READ;
                end
            end
            tvs_pkg::B_READ: begin
                if (r_corner == tvs_pkg::LAST_CORNER) begin
                    n_state = tvs_pkg::B_DRAIN;
                end
            end
            tvs_pkg::B_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = tvs_pkg::B_IDLE;
                end
            end
            default: n_state = tvs_pkg::B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_pop    = 1'b0;
        w_mem_we = 1'b0;
        w_issue  = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            tvs_pkg::B_IDLE: begin
                w_pop    = i_q_valid;
                w_mem_we = i_q_valid && !i_q_ctl.is_sample && w_wr_ok;
            end
            tvs_pkg::B_READ: begin
                w_issue = 1'b1;
            end
            tvs_pkg::B_DRAIN: begin
                w_finish = w_pipe_empty;
            end
            default: begin
                w_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tvs_pkg::B_IDLE;
            r_corner    <= '0;
            r_t1_v      <= 1'b0;
            r_t2_v      <= 1'b0;
            r_t3_v      <= 1'b0;
            r_t4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (w_issue) begin
                r_corner <= r_corner + 3'd1;
            end
            r_t1_v      <= w_issue;
            r_t2_v      <= r_t1_v;
            r_t3_v      <= r_t2_v;
            r_t4_v      <= r_t3_v;
            r_out_valid <= (w_pop && w_outside) || w_finish;
        end
    end

    // cell setup on pop
    always_ff @(posedge i_clk) begin
        if (w_pop && w_start_cell) begin
            r_base <= i_q_addr;
            r_fx   <= i_q_fx;
            r_fy   <= i_q_fy;
            r_fz   <= i_q_fz;
        end
    end

    // single-port voxel memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_voxel_mem[i_q_addr[MEM_AW-1:0]] <= i_q_value;
        end
        if (w_issue) begin
            r_rdata <= r_voxel_mem[w_caddr[MEM_AW-1:0]];
        end
    end

    // corner bit set picks f, clear picks one minus f
    assign w_wx  = r_t1_corner[0] ? {1'b0, r_fx} : (ONE - {1'b0, r_fx});
    assign w_wy  = r_t2_corner[0] ? {1'b0, r_fy} : (ONE - {1'b0, r_fy});
    assign w_wz  = r_t3_corner    ? {1'b0, r_fz} : (ONE - {1'b0, r_fz});
    assign w_vox = r_t1_zero ? '0 : $signed(r_rdata);
    assign w_p3  = r_p2 * $signed({1'b0, w_wz});

    always_ff @(posedge i_clk) begin
        r_t1_zero   <= w_corner_oob;
        r_t1_corner <= r_corner;
        r_t2_corner <= r_t1_corner[2:1];
        r_t3_corner <= r_t2_corner[1];
        r_p1        <= w_vox * $signed({1'b0, w_wx});
        r_p2        <= r_p1 * $signed({1'b0, w_wy});
        r_p3        <= w_p3[OW-1:0];
        if (w_pop && w_start_cell) begin
            r_acc <= '0;
        end else if (r_t4_v) begin
            r_acc <= r_acc + r_p3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= w_finish;
        r_out_value  <= w_finish ? r_acc : '0;
    end

    assign o_q_pop        = w_pop;
    assign o_result_valid = r_out_valid;
    assign o_sample_value = r_out_value;
    assign o_inside_res   = r_out_inside;

`ifndef SYNTH
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == tvs_pkg::B_DRAIN
                         || $past(r_state) == tvs_pkg::B_IDLE))
        else $error("result strobe from an unexpected state");
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_inside) |-> (r_out_value == '0))
        else $error("outside result carries a nonzero value");
    a_corner_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tvs_pkg::B_READ) |-> (r_corner == '0))
        else $error("corner counter left running outside the read sequence");
`endif

endmodule

`default_nettype wire

[src/trilinear_volume_sampler.sv]
// top level of the trilinear volume sampler: config registers, front, queue and back
`timescale 1ns / 1ps
`default_nettype none

// Trilinear volume sampler
//
// command channel: a beat is taken at a rising edge with i_start high and o_busy
// low. i_action = 0 writes i_voxel_value at i_voxel_address (x-fastest linear
// index) and gives no result; i_action = 1 samples at i_coord_x/y/z, signed
// fixed point with FRACTION_BITS fraction bits.
// result channel: o_result_valid is high for exactly one cycle per sample, with
// o_sample_value (3*FRACTION_BITS fraction bits) and o_inside_res. a cell that
// does not lie wholly inside dim_x/y/z gives o_inside_res = 0 and a zero value.
// the receiver cannot stall, so results never back up.
// config port: APB-style, dim_x at 0x0, dim_y at 0x4, dim_z at 0x8, pready
// always high; write only while no beat is in flight.
// pipeline: a two-stage front feeds a four-entry queue; the back reads the eight
// corners from one single-port voxel memory, one per cycle, then a three-multiply
// weight pipeline and an accumulator. an inside sample holds the back in its read
// and drain states, so the back takes no new beat until the products of that
// sample are accumulated; an outside sample or a voxel write is done as it is
// popped. o_busy rises when the queue plus the front stages hold four beats.
// reset: dims go to 64, queue and pipelines empty; the voxel memory is not
// cleared and must be written before it is sampled.

module trilinear_volume_sampler #(
    parameter int VOXEL_CAPACITY = 262144,
    parameter int VOXEL_BITS     = 16,
    parameter int FRACTION_BITS  = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    output logic                                 o_busy,
    input  wire                                  i_action,
    input  wire         [tvs_pkg::ADDR_IN_W-1:0] i_voxel_address,
    input  wire signed  [tvs_pkg::VALUE_IN_W-1:0] i_voxel_value,
    input  wire signed  [tvs_pkg::COORD_W-1:0]   i_coord_x,
    input  wire signed  [tvs_pkg::COORD_W-1:0]   i_coord_y,
    input  wire signed  [tvs_pkg::COORD_W-1:0]   i_coord_z,
    output logic                                 o_result_valid,
    output logic signed [tvs_pkg::OUT_W-1:0]     o_sample_value,
    output logic                                 o_inside_res,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire         [3:0]                    paddr,
    input  wire         [31:0]                   pwdata,
    output logic        [31:0]                   prdata,
    output logic                                 pready
);

    localparam int MEM_AW = $clog2(VOXEL_CAPACITY);
    // cell addresses need 21 bits for dims up to 127; wider when the memory is larger
    localparam int CA_W   = (MEM_AW > tvs_pkg::CELL_ADDR_W) ? MEM_AW : tvs_pkg::CELL_ADDR_W;
    localparam int FB     = FRACTION_BITS;
    // queue entry: ctl, address, value, three fractions
    localparam int ENT_W  = 2 + CA_W + VOXEL_BITS + 3 * FB;

    // config registers; dim_x*dim_y is kept ready for the z stride
    logic [tvs_pkg::DIM_W-1:0]    r_dim_x;
    logic [tvs_pkg::DIM_W-1:0]    r_dim_y;
    logic [tvs_pkg::DIM_W-1:0]    r_dim_z;
    logic [tvs_pkg::DIM_XY_W-1:0] r_dim_xy;
    logic [tvs_pkg::DIM_W-1:0]    n_dim_x;
    logic [tvs_pkg::DIM_W-1:0]    n_dim_y;
    logic [tvs_pkg::DIM_W-1:0]    n_dim_z;
    logic [tvs_pkg::DIM_XY_W-1:0] n_dim_xy;
    logic                         w_cfg_wr;
    logic [tvs_pkg::DIM_W-1:0]    w_wdim;

    // front to queue
    logic                         w_push;
    tvs_pkg::t_cmd_ctl            w_push_ctl;
    logic [CA_W-1:0]              w_push_addr;
    logic [VOXEL_BITS-1:0]        w_push_value;
    logic [FB-1:0]                w_push_fx;
    logic [FB-1:0]                w_push_fy;
    logic [FB-1:0]                w_push_fz;
    logic [ENT_W-1:0]             w_push_data;

    // queue to back
    logic [ENT_W-1:0]             w_head;
    logic                         w_q_valid;
    logic [tvs_pkg::Q_CNT_W-1:0]  w_q_count;
    logic                         w_q_pop;
    tvs_pkg::t_cmd_ctl            w_head_ctl;
    logic [CA_W-1:0]              w_head_addr;
    logic [VOXEL_BITS-1:0]        w_head_value;
    logic [FB-1:0]                w_head_fx;
    logic [FB-1:0]                w_head_fy;
    logic [FB-1:0]                w_head_fz;

    // ---------------- config port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_wdim   = pwdata[tvs_pkg::DIM_W-1:0];

    always_comb begin
        n_dim_x  = r_dim_x;
        n_dim_y  = r_dim_y;
        n_dim_z  = r_dim_z;
        n_dim_xy = r_dim_xy;
        if (w_cfg_wr) begin
            unique case (paddr[3:2])
                tvs_pkg::REG_DIM_X: begin
                    n_dim_x  = w_wdim;
                    n_dim_xy = w_wdim * r_dim_y;
                end
                tvs_pkg::REG_DIM_Y: begin
                    n_dim_y  = w_wdim;
                    n_dim_xy = r_dim_x * w_wdim;
                end
                tvs_pkg::REG_DIM_Z: begin
                    n_dim_z  = w_wdim;
                end
                default: begin
                    n_dim_z  = r_dim_z;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x  <= tvs_pkg::DIM_RESET;
            r_dim_y  <= tvs_pkg::DIM_RESET;
            r_dim_z  <= tvs_pkg::DIM_RESET;
            r_dim_xy <= tvs_pkg::DIM_XY_RESET;
        end else begin
            r_dim_x  <= n_dim_x;
            r_dim_y  <= n_dim_y;
            r_dim_z  <= n_dim_z;
            r_dim_xy <= n_dim_xy;
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            tvs_pkg::REG_DIM_X: prdata = 32'(r_dim_x);
            tvs_pkg::REG_DIM_Y: prdata = 32'(r_dim_y);
            tvs_pkg::REG_DIM_Z: prdata = 32'(r_dim_z);
            default:            prdata = '0;
        endcase
    end

    // ---------------- front: accept, split, classify ----------------
    tvs_front #(
        .VOXEL_BITS    (VOXEL_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CA_W          (CA_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_voxel_address (i_voxel_address),
        .i_voxel_value   (i_voxel_value),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_dim_x         (r_dim_x),
        .i_dim_y         (r_dim_y),
        .i_dim_z         (r_dim_z),
        .i_dim_xy        (r_dim_xy),
        .i_q_count       (w_q_count),
        .o_push          (w_push),
        .o_push_ctl      (w_push_ctl),
        .o_push_addr     (w_push_addr),
        .o_push_value    (w_push_value),
        .o_push_fx       (w_push_fx),
        .o_push_fy       (w_push_fy),
        .o_push_fz       (w_push_fz)
    );

    // ---------------- command queue ----------------
    // writes travel through the queue too, so memory updates stay in beat order
    assign w_push_data = {w_push_ctl, w_push_addr, w_push_value,
                          w_push_fx, w_push_fy, w_push_fz};

    tvs_queue #(
        .DATA_W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_q_pop),
        .o_data  (w_head),
        .o_valid (w_q_valid),
        .o_count (w_q_count)
    );

    assign {w_head_ctl, w_head_addr, w_head_value,
            w_head_fx, w_head_fy, w_head_fz} = w_head;

    // ---------------- back: memory, corner reads, blend ----------------
    tvs_back #(
        .VOXEL_CAPACITY (VOXEL_CAPACITY),
        .VOXEL_BITS     (VOXEL_BITS),
        .FRACTION_BITS  (FRACTION_BITS),
        .MEM_AW         (MEM_AW),
        .CA_W           (CA_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_ctl        (w_head_ctl),
        .i_q_addr       (w_head_addr),
        .i_q_value      (w_head_value),
        .i_q_fx         (w_head_fx),
        .i_q_fy         (w_head_fy),
        .i_q_fz         (w_head_fz),
        .i_dim_x        (r_dim_x),
        .i_dim_xy       (r_dim_xy),
        .o_q_pop        (w_q_pop),
        .o_result_valid (o_result_valid),
        .o_sample_value (o_sample_value),
        .o_inside_res   (o_inside_res)
    );

endmodule

`default_nettype wire

[dv/tb_trilinear_volume_sampler.sv]
// testbench of the trilinear volume sampler: random voxel writes and samples checked against a predictor
`timescale 1ns / 1ps

module tb_trilinear_volume_sampler;

    // input beat kinds on i_action
    localparam bit ACT_WRITE  = 1'b0;
    localparam bit ACT_SAMPLE = 1'b1;

    localparam int  CAPACITY    = 262144;
    localparam int  FRACTION    = 8;
    localparam int  ONE         = 1 << FRACTION;
    localparam int  PHASE_BEATS = 50;
    localparam int  N_PHASES    = 10;
    // back-end drain time after the last result, writes give no result
    localparam int  DRAIN       = 48;
    // cycles without any beat moving before the run is called hung
    localparam int  STALL_LIMIT = 2000;

    typedef struct {
        logic signed [tvs_pkg::OUT_W-1:0] value;
        logic                             in_cell;
    } t_sample_result;

    // predictor: holds its own copy of the voxel store and the dims,
    // turns each accepted beat into the expected result
    class sampler_scoreboard;
        logic signed [tvs_pkg::VALUE_IN_W-1:0] voxels [int];
        int                                    dim_x;
        int                                    dim_y;
        int                                    dim_z;
        t_sample_result                        expected_q [$];
        int                                    errors;

        function new();
            dim_x  = 64;
            dim_y  = 64;
            dim_z  = 64;
            errors = 0;
        endfunction

        function void set_dim(logic [1:0] idx, logic [tvs_pkg::DIM_W-1:0] v);
            case (idx)
                tvs_pkg::REG_DIM_X: dim_x = int'(v);
                tvs_pkg::REG_DIM_Y: dim_y = int'(v);
                tvs_pkg::REG_DIM_Z: dim_z = int'(v);
                default: ;
            endcase
        endfunction

        // linear address of one cell corner, x fastest
        function longint cell_address(int x0, int y0, int z0, int i, int j, int k);
            return longint'(x0 + i) + longint'(y0 + j) * dim_x
                   + longint'(z0 + k) * dim_x * dim_y;
        endfunction

        // whole cell lies within the current dims
        function bit cell_fits(int x0, int y0, int z0);
            return x0 >= 0 && y0 >= 0 && z0 >= 0 &&
                   x0 + 1 < dim_x && y0 + 1 < dim_y && z0 + 1 < dim_z;
        endfunction

        function bit has_voxel(longint a);
            return voxels.exists(int'(a));
        endfunction

        function longint voxel_at(longint a);
            // corners past the store read as zero
            if (a >= CAPACITY || !voxels.exists(int'(a)))
                return 0;
            return longint'(voxels[int'(a)]);
        endfunction

        function void note_beat(bit act, logic [tvs_pkg::ADDR_IN_W-1:0] addr,
                                logic signed [tvs_pkg::VALUE_IN_W-1:0] val,
                                logic signed [tvs_pkg::COORD_W-1:0] cx,
                                logic signed [tvs_pkg::COORD_W-1:0] cy,
                                logic signed [tvs_pkg::COORD_W-1:0] cz);
            int             x0, y0, z0;
            longint         fx, fy, fz, w, acc;
            t_sample_result r;
            if (act == ACT_WRITE) begin
                voxels[int'(addr)] = val;
                return;
            end
            // floor and fraction of each coordinate
            x0 = int'(cx >>> FRACTION);
            y0 = int'(cy >>> FRACTION);
            z0 = int'(cz >>> FRACTION);
            fx = longint'(cx[FRACTION-1:0]);
            fy = longint'(cy[FRACTION-1:0]);
            fz = longint'(cz[FRACTION-1:0]);
            r.value   = '0;
            r.in_cell = 1'b0;
            if (cell_fits(x0, y0, z0)) begin
                acc = 0;
                for (int k = 0; k < 2; k++)
                    for (int j = 0; j < 2; j++)
                        for (int i = 0; i < 2; i++) begin
                            w = (i ? fx : ONE - fx) * (j ? fy : ONE - fy)
                                * (k ? fz : ONE - fz);
                            acc += w * voxel_at(cell_address(x0, y0, z0, i, j, k));
                        end
                r.value   = acc[tvs_pkg::OUT_W-1:0];
                r.in_cell = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [tvs_pkg::OUT_W-1:0] v, logic ins);
            t_sample_result e;
            if (expected_q.size() == 0) begin
                $error("result beat with no sample waiting: sample_value %0d, inside_res %b",
                       v, ins);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value) begin
                $error("sample_value: expected %0d, actual %0d", e.value, v);
                errors++;
            end
            if (ins !== e.in_cell) begin
                $error("inside_res: expected %b, actual %b", e.in_cell, ins);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_start = 1'b0;
    logic                                  o_busy;
    logic                                  i_action = 1'b0;
    logic        [tvs_pkg::ADDR_IN_W-1:0]  i_voxel_address = '0;
    logic signed [tvs_pkg::VALUE_IN_W-1:0] i_voxel_value = '0;
    logic signed [tvs_pkg::COORD_W-1:0]    i_coord_x = '0;
    logic signed [tvs_pkg::COORD_W-1:0]    i_coord_y = '0;
    logic signed [tvs_pkg::COORD_W-1:0]    i_coord_z = '0;
    logic                                  o_result_valid;
    logic signed [tvs_pkg::OUT_W-1:0]      o_sample_value;
    logic                                  o_inside_res;
    logic                                  psel = 1'b0;
    logic                                  penable = 1'b0;
    logic                                  pwrite = 1'b0;
    logic        [3:0]                     paddr = '0;
    logic        [31:0]                    pwdata = '0;
    logic        [31:0]                    prdata;
    logic                                  pready;

    sampler_scoreboard sb;
    bit                idle_mode;
    int                phase_beats;

    trilinear_volume_sampler DUT (.*);

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // every sampled result beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            sb.check_result(o_sample_value, o_inside_res);
    end

    // hang detector: counts cycles in which no beat of any kind moves
    always @(posedge i_clk) begin
        static int stall = 0;
        if (!i_rst_n || (i_start && !o_busy) || o_result_valid === 1'b1 || psel)
            stall = 0;
        else begin
            stall++;
            if (stall >= STALL_LIMIT) begin
                $error("no beat moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [tvs_pkg::VALUE_IN_W-1:0] rand_voxel();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return tvs_pkg::VALUE_IN_W'($urandom);
        endcase
    endfunction

    // floors lean toward the two ends of the range
    function automatic int pick_floor(int dim);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return dim - 2;
            default: return $urandom_range(0, dim - 2);
        endcase
    endfunction

    function automatic int pick_frac();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return ONE - 1;
            default: return $urandom_range(0, ONE - 1);
        endcase
    endfunction

    // one command beat: optional idle burst, then hold start until taken
    task automatic send_beat(bit act, logic [tvs_pkg::ADDR_IN_W-1:0] addr,
                             logic signed [tvs_pkg::VALUE_IN_W-1:0] val,
                             logic signed [tvs_pkg::COORD_W-1:0] cx,
                             logic signed [tvs_pkg::COORD_W-1:0] cy,
                             logic signed [tvs_pkg::COORD_W-1:0] cz);
        int gap;
        if (idle_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start         <= 1'b1;
        i_action        <= act;
        i_voxel_address <= addr;
        i_voxel_value   <= val;
        i_coord_x       <= cx;
        i_coord_y       <= cy;
        i_coord_z       <= cz;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_beat(act, addr, val, cx, cy, cz);
        phase_beats++;
    endtask

    // sample with unused write fields filled with noise
    task automatic send_sample(logic signed [tvs_pkg::COORD_W-1:0] cx,
                               logic signed [tvs_pkg::COORD_W-1:0] cy,
                               logic signed [tvs_pkg::COORD_W-1:0] cz);
        send_beat(ACT_SAMPLE, tvs_pkg::ADDR_IN_W'($urandom),
                  tvs_pkg::VALUE_IN_W'($urandom), cx, cy, cz);
    endtask

    // write any corner of the cell that is still unwritten (and a few again),
    // then sample inside it; corners past the store are left alone
    task automatic sample_cell(int x0, int y0, int z0, int fx, int fy, int fz,
                               bit fixed, logic signed [tvs_pkg::VALUE_IN_W-1:0] fixed_val);
        longint a;
        for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++) begin
                    a = sb.cell_address(x0, y0, z0, i, j, k);
                    if (a < CAPACITY &&
                        (fixed || !sb.has_voxel(a) || $urandom_range(0, 5) == 0))
                        send_beat(ACT_WRITE, a[tvs_pkg::ADDR_IN_W-1:0],
                                  fixed ? fixed_val : rand_voxel(),
                                  tvs_pkg::COORD_W'($urandom),
                                  tvs_pkg::COORD_W'($urandom),
                                  tvs_pkg::COORD_W'($urandom));
                end
        send_sample(tvs_pkg::COORD_W'(x0 * ONE + fx), tvs_pkg::COORD_W'(y0 * ONE + fy),
                    tvs_pkg::COORD_W'(z0 * ONE + fz));
    endtask

    task automatic random_sequence();
        int                                 axis, fl;
        int                                 x0, y0, z0;
        logic signed [tvs_pkg::COORD_W-1:0] c [3];
        case ($urandom_range(0, 9))
            6: begin
                // stray write anywhere in the address space
                send_beat(ACT_WRITE, tvs_pkg::ADDR_IN_W'($urandom), rand_voxel(),
                          tvs_pkg::COORD_W'($urandom), tvs_pkg::COORD_W'($urandom),
                          tvs_pkg::COORD_W'($urandom));
            end
            7: begin
                // cell one step past an edge on one axis
                for (int n = 0; n < 3; n++)
                    c[n] = tvs_pkg::COORD_W'($urandom_range(0, 64 * ONE));
                axis = $urandom_range(0, 2);
                fl = $urandom_range(0, 1) ? -1
                   : (axis == 0 ? sb.dim_x : axis == 1 ? sb.dim_y : sb.dim_z) - 1;
                c[axis] = tvs_pkg::COORD_W'(fl * ONE + $urandom_range(0, ONE - 1));
                send_sample(c[0], c[1], c[2]);
            end
            8: begin
                // coordinates over their whole range, nearly always outside;
                // a cell that happens to fit gets its corners written first
                for (int n = 0; n < 3; n++)
                    c[n] = tvs_pkg::COORD_W'($urandom);
                x0 = int'(c[0] >>> FRACTION);
                y0 = int'(c[1] >>> FRACTION);
                z0 = int'(c[2] >>> FRACTION);
                if (sb.cell_fits(x0, y0, z0))
                    sample_cell(x0, y0, z0, int'(c[0][FRACTION-1:0]),
                                int'(c[1][FRACTION-1:0]), int'(c[2][FRACTION-1:0]),
                                1'b0, '0);
                else
                    send_sample(c[0], c[1], c[2]);
            end
            default: begin
                if (sb.dim_x >= 2 && sb.dim_y >= 2 && sb.dim_z >= 2)
                    sample_cell(pick_floor(sb.dim_x), pick_floor(sb.dim_y),
                                pick_floor(sb.dim_z), pick_frac(), pick_frac(),
                                pick_frac(), 1'b0, '0);
                else
                    // no cell fits, every sample lands outside
                    send_sample(tvs_pkg::COORD_W'($urandom_range(0, 64 * ONE)),
                                tvs_pkg::COORD_W'($urandom_range(0, 64 * ONE)),
                                tvs_pkg::COORD_W'($urandom_range(0, 64 * ONE)));
            end
        endcase
    endtask

    // stop sending and let the back end empty out
    task automatic settle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // register write with a setup and an access phase, upper data bits are noise
    task automatic write_reg(logic [1:0] idx, logic [tvs_pkg::DIM_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom), v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_dim(idx, v);
    endtask

    initial begin
        int dims_x [N_PHASES];
        int dims_y [N_PHASES];
        int dims_z [N_PHASES];
        sb = new();
        idle_mode   = 1'b1;
        phase_beats = 0;

        // phase dims: smallest cube, odd sizes, reset size, below-two dims,
        // register maximum (corners past the store), flat shapes, then random
        dims_x = '{2, 3, 64, 0, 127, 1, 64, 0, 0, 0};
        dims_y = '{2, 5, 64, 1, 127, 64, 2, 0, 0, 0};
        dims_z = '{2, 7, 64, 5, 127, 2, 3, 0, 0, 0};
        for (int p = 7; p < N_PHASES; p++) begin
            dims_x[p] = $urandom_range(2, 64);
            dims_y[p] = $urandom_range(2, 64);
            dims_z[p] = $urandom_range(2, 64);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset dims 64x64x64
        // cell at the origin, all corners at the most negative voxel
        sample_cell(0, 0, 0, 0, 0, 0, 1'b1, 16'sh8000);
        send_sample(tvs_pkg::COORD_W'(ONE - 1), tvs_pkg::COORD_W'(ONE - 1),
                    tvs_pkg::COORD_W'(ONE - 1));
        // last cell that still fits, largest voxels, mixed weights
        sample_cell(62, 62, 62, ONE - 1, ONE / 2, 1, 1'b1, 16'sh7fff);
        // just below zero, one past the far edge, coordinate extremes
        send_sample(-18'sd1, 18'sd0, 18'sd0);
        send_sample(tvs_pkg::COORD_W'(63 * ONE), 18'sd256, 18'sd256);
        send_sample(18'sd0, tvs_pkg::COORD_W'(-131072), 18'sd0);
        send_sample(18'sd0, 18'sd0, 18'sd131071);
        // top of the address range, also the far corner of the last cell at these dims
        send_beat(ACT_WRITE, 18'h3ffff, rand_voxel(),
                  tvs_pkg::COORD_W'($urandom), tvs_pkg::COORD_W'($urandom),
                  tvs_pkg::COORD_W'($urandom));

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            write_reg(tvs_pkg::REG_DIM_X, tvs_pkg::DIM_W'(dims_x[p]));
            write_reg(tvs_pkg::REG_DIM_Y, tvs_pkg::DIM_W'(dims_y[p]));
            write_reg(tvs_pkg::REG_DIM_Z, tvs_pkg::DIM_W'(dims_z[p]));
            // the last phase runs without any idling
            idle_mode   = (p != N_PHASES - 1);
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                if (p != N_PHASES - 1 && $urandom_range(0, 7) == 0)
                    idle_mode = !idle_mode;
                random_sequence();
            end
        end

        settle();
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
